// ----- src/gic_pkg.sv -----
// ============================================================================
// gic_pkg
// Shared types and constants of the greedy interval cover block: sequencer
// states, configuration register indexes and the result count format.
// ============================================================================
package gic_pkg;

    // Configuration register indexes
    localparam logic REG_RANGE_START = 1'b0;
    localparam logic REG_RANGE_END   = 1'b1;

    // Result count format, saturating
    localparam int unsigned COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Cover sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_STEP,
        ST_DONE
    } state_t;

endpackage

// ----- src/gic_cell.sv -----
// ============================================================================
// gic_cell
// One cell of the interval chain. Holds one stored interval, passes it to the
// next cell while loading, and during a scan passes on the furthest reach seen
// so far, raised to its own end when its interval starts at or before the
// covered point.
// ============================================================================
module gic_cell
    import gic_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int CNT_W      = 9,
    parameter int IDX        = 0
)
(
    input  logic                  clk,
    input  logic                  shift_en,
    input  logic [COORD_BITS-1:0] start_in,
    input  logic [COORD_BITS-1:0] end_in,
    output logic [COORD_BITS-1:0] start_out,
    output logic [COORD_BITS-1:0] end_out,
    input  logic [CNT_W-1:0]      loaded_count,
    input  logic [COORD_BITS-1:0] covered,
    input  logic [COORD_BITS-1:0] reach_in,
    output logic [COORD_BITS-1:0] reach_out
);

    logic [COORD_BITS-1:0] start_reg;
    logic [COORD_BITS-1:0] end_reg;
    logic [COORD_BITS-1:0] reach_reg;
    logic [COORD_BITS-1:0] reach_next;
    logic                  occupied;

    // Cell holds a live interval when its place lies below the fill count
    assign occupied = (CNT_W'(IDX) < loaded_count);

    // Raise the reach when this interval applies and extends further
    always_comb
    begin
        if (occupied && (start_reg <= covered) && (end_reg > reach_in))
        begin
            reach_next = end_reg;
        end
        else
        begin
            reach_next = reach_in;
        end
    end

    // Shift the stored interval along the chain on each load transfer
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            start_reg <= start_in;
            end_reg   <= end_in;
        end
    end

    // Advance the reach wave one cell per cycle
    always_ff @(posedge clk)
    begin
        reach_reg <= reach_next;
    end

    assign start_out = start_reg;
    assign end_out   = end_reg;
    assign reach_out = reach_reg;

endmodule

// ----- src/greedy_interval_cover.sv -----
// ============================================================================
// greedy_interval_cover
// Stores a set of closed intervals in a chain of cells and finds the fewest
// of them that cover [range_start, range_end], greedily by furthest reach.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------
//  in       sink       in_valid / in_stall  interval_start, interval_end,
//                                           last_interval
//  out      source     out_valid/out_stall  cover_count, impossible
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Loading takes one interval per cycle. After the last interval the scan runs
//  in rounds; each round sends a reach wave down the whole chain and ends in
//  one greedy step. A set covered in r steps (or failing at step r) needs r
//  rounds. The input is stalled from the last transfer until the result is
//  registered, and longer while an earlier result still waits at the output.
//  A waiting result does not block loading of the next set. Reset clears the
//  fill count, the sequencer and both range registers; cell contents are left
//  as they are.
//
module greedy_interval_cover
    import gic_pkg::*;
#(
    parameter int MAX_INTERVALS = 256,
    parameter int COORD_BITS    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] interval_start,
    input  logic [COORD_BITS-1:0] interval_end,
    input  logic                  last_interval,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COUNT_W-1:0]    cover_count,
    output logic                  impossible,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int RND_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    state_t                state_reg,        state_next;
    logic [CNT_W-1:0]      loaded_count_reg, loaded_count_next;
    logic [COORD_BITS-1:0] covered_reg,      covered_next;
    logic [COUNT_W-1:0]    chosen_reg,       chosen_next;
    logic [RND_W-1:0]      round_cnt_reg,    round_cnt_next;
    logic                  fail_reg,         fail_next;
    logic                  out_valid_reg,    out_valid_next;
    logic [COUNT_W-1:0]    out_count_reg,    out_count_next;
    logic                  out_imp_reg,      out_imp_next;
    logic [COORD_BITS-1:0] range_start_reg;
    logic [COORD_BITS-1:0] range_end_reg;

    logic                  in_xfer;
    logic                  shift_en;
    logic [COORD_BITS-1:0] start_chain [MAX_INTERVALS];
    logic [COORD_BITS-1:0] end_chain   [MAX_INTERVALS];
    logic [COORD_BITS-1:0] reach_chain [MAX_INTERVALS];
    logic [COORD_BITS-1:0] tail_reach;

    assign in_xfer  = in_valid && !in_stall;
    assign shift_en = in_xfer && (loaded_count_reg < CNT_W'(MAX_INTERVALS));

    // Chain of interval cells: cell 0 takes new intervals and the covered point
    for (genvar i = 0; i < MAX_INTERVALS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            gic_cell #(
                .COORD_BITS (COORD_BITS),
                .CNT_W      (CNT_W),
                .IDX        (i)
            ) u_cell (
                .clk          (clk),
                .shift_en     (shift_en),
                .start_in     (interval_start),
                .end_in       (interval_end),
                .start_out    (start_chain[i]),
                .end_out      (end_chain[i]),
                .loaded_count (loaded_count_reg),
                .covered      (covered_reg),
                .reach_in     (covered_reg),
                .reach_out    (reach_chain[i])
            );
        end
        else
        begin : g_body
            gic_cell #(
                .COORD_BITS (COORD_BITS),
                .CNT_W      (CNT_W),
                .IDX        (i)
            ) u_cell (
                .clk          (clk),
                .shift_en     (shift_en),
                .start_in     (start_chain[i-1]),
                .end_in       (end_chain[i-1]),
                .start_out    (start_chain[i]),
                .end_out      (end_chain[i]),
                .loaded_count (loaded_count_reg),
                .covered      (covered_reg),
                .reach_in     (reach_chain[i-1]),
                .reach_out    (reach_chain[i])
            );
        end
    end

    assign tail_reach = reach_chain[MAX_INTERVALS-1];

    // Configuration registers; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= '0;
            range_end_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RANGE_START: range_start_reg <= cfg_data;
                REG_RANGE_END:   range_end_reg   <= cfg_data;
                default:         range_end_reg   <= range_end_reg;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            loaded_count_reg <= '0;
            round_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            round_cnt_reg    <= round_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Scan and result payload registers
    always_ff @(posedge clk)
    begin
        covered_reg   <= covered_next;
        chosen_reg    <= chosen_next;
        fail_reg      <= fail_next;
        out_count_reg <= out_count_next;
        out_imp_reg   <= out_imp_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        covered_next      = covered_reg;
        chosen_next       = chosen_reg;
        round_cnt_next    = round_cnt_reg;
        fail_next         = fail_reg;
        out_valid_next    = out_valid_reg;
        out_count_next    = out_count_reg;
        out_imp_next      = out_imp_reg;
        in_stall          = (state_reg != ST_LOAD);

        // Drop the result once the output transfer completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (shift_en)
                begin
                    loaded_count_next = loaded_count_reg + CNT_W'(1);
                end
                if (in_xfer && last_interval)
                begin
                    covered_next = range_start_reg;
                    chosen_next  = '0;
                    fail_next    = 1'b0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (covered_reg >= range_end_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    round_cnt_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                round_cnt_next = round_cnt_reg + RND_W'(1);
                if (round_cnt_reg == RND_W'(MAX_INTERVALS - 1))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (tail_reach <= covered_reg)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (chosen_reg != COUNT_MAX)
                    begin
                        chosen_next = chosen_reg + COUNT_W'(1);
                    end
                    covered_next = tail_reach;
                    state_next   = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_count_next    = fail_reg ? '0 : chosen_reg;
                    out_imp_next      = fail_reg;
                    loaded_count_next = '0;
                    state_next        = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign cover_count = out_count_reg;
    assign impossible  = out_imp_reg;

    // Fill count stays within the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= CNT_W'(MAX_INTERVALS))
        else $error("fill count beyond chain length");

    // A new result only appears when leaving the done state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done state");

    // A scan round is only evaluated while the range is still open
    a_step_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> covered_reg < range_end_reg)
        else $error("scan step on a covered range");

    // A successful step moves the covered point strictly forward
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && tail_reach > covered_reg)
            |=> covered_reg > $past(covered_reg))
        else $error("covered point did not advance");

    // An impossible result carries a zero count
    a_imp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_imp_reg) |-> out_count_reg == '0)
        else $error("impossible result with nonzero count");

endmodule
